FILE: sv/deq_pkg.sv
package deq_pkg;

   // sizing of the store
   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int IDX_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // fixed widths of the transaction fields
   localparam int REQ_TYPE_WIDTH = 3;
   localparam int PORT_WIDTH     = 32;
   localparam int STATUS_WIDTH   = 2;
   localparam int FILL_WIDTH     = 5;

   // request codes
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_PEEK_BACK  = 3'd5;

   // status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

   typedef logic signed [DATA_WIDTH-1:0]  word_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;
   typedef logic [IDX_WIDTH-1:0]          index_type;

   typedef struct packed {
      logic [REQ_TYPE_WIDTH-1:0]    req_type;
      logic signed [PORT_WIDTH-1:0] data_in;
   } deq_req_type;

   typedef struct packed {
      logic signed [PORT_WIDTH-1:0] data_out;
      logic [STATUS_WIDTH-1:0]      status;
      logic [FILL_WIDTH-1:0]        fill_count;
   } deq_rsp_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic      shift_right;
      logic      shift_left;
      logic      write_back;
      count_type count;
      word_type  new_word;
   } deq_cell_ctrl_type;

endpackage

FILE: sv/deq_cell.sv
module deq_cell
   import deq_pkg::*;
(
   input  logic              clock,
   input  index_type         cell_index,
   input  deq_cell_ctrl_type ctrl,
   input  word_type          left_word,
   input  word_type          right_word,
   output word_type          word,
   output word_type          back_word
);

   word_type  word_ff;
   word_type  word_in;
   count_type own_place;

   assign own_place = COUNT_WIDTH'(cell_index);

   // next content: shift from a neighbour, take the new word or hold
   always_comb begin
      word_in = word_ff;
      if (ctrl.shift_right) begin
         word_in = (cell_index == '0) ? ctrl.new_word : left_word;
      end else if (ctrl.shift_left) begin
         word_in = right_word;
      end else if (ctrl.write_back && (own_place == ctrl.count)) begin
         word_in = ctrl.new_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // this cell drives the back word only when it holds the last entry
   assign word      = word_ff;
   assign back_word = ((own_place + COUNT_WIDTH'(1)) == ctrl.count) ? word_ff : '0;

endmodule

FILE: sv/double_ended_queue.sv
// bounded double-ended queue built as a row of shifting cells
//
// request channel: a transaction is taken at a rising edge with start high and
// busy low; req_payload carries the request code and the word for pushes.
// codes are push front, push back, pop front, pop back, peek front, peek back.
// busy stays low, so a new request may be taken in every cycle.
//
// result channel: one result per request, shown on rsp_payload for a single
// cycle with rsp_valid high, in the cycle after the request is taken. it holds
// the word read (zero for pushes and errors), a status (ok, empty or full
// error) and the fill count after the request. the receiver cannot stall.
//
// every request is done at the edge that takes it: the chain shifts, one cell
// loads or (pop back, peeks, errors) none changes, in the same edge that updates
// the count; the back entry is picked by the cell whose place is the count less one.
//
// reset empties the queue and drops any pending result; cell contents are
// left as they are and are never read before a push writes them.
module double_ended_queue
   import deq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  deq_req_type req_payload,
   output logic        rsp_valid,
   output deq_rsp_type rsp_payload
);

   count_type                count_ff;
   count_type                count_in;
   logic                     rsp_valid_ff;
   deq_rsp_type              rsp_ff;
   deq_rsp_type              rsp_in;
   deq_cell_ctrl_type        ctrl;
   word_type                 cell_word [DEPTH];
   word_type                 cell_back [DEPTH];
   word_type                 back_word;
   word_type                 read_word;
   logic [STATUS_WIDTH-1:0]  rsp_status;
   logic                     accept;
   logic                     is_full;
   logic                     is_empty;

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == COUNT_WIDTH'(DEPTH));
   assign is_empty = (count_ff == '0);

   // back entry gathered from the one cell that flags it
   always_comb begin
      back_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_word = back_word | cell_back[i];
      end
   end

   // request decode
   always_comb begin
      ctrl.shift_right = 1'b0;
      ctrl.shift_left  = 1'b0;
      ctrl.write_back  = 1'b0;
      ctrl.count       = count_ff;
      ctrl.new_word    = DATA_WIDTH'(req_payload.data_in);
      count_in         = count_ff;
      rsp_status       = ST_OK;
      unique case (req_payload.req_type) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (is_full) begin
               rsp_status = ST_FULL;
            end else begin
               ctrl.shift_right = accept && (req_payload.req_type == OP_PUSH_FRONT);
               ctrl.write_back  = accept && (req_payload.req_type == OP_PUSH_BACK);
               count_in         = count_ff + COUNT_WIDTH'(1);
            end
         end
         OP_POP_FRONT, OP_PEEK_FRONT: begin
            if (is_empty) begin
               rsp_status = ST_EMPTY;
            end else if (req_payload.req_type == OP_POP_FRONT) begin
               ctrl.shift_left = accept;
               count_in        = count_ff - COUNT_WIDTH'(1);
            end
         end
         OP_POP_BACK, OP_PEEK_BACK: begin
            if (is_empty) begin
               rsp_status = ST_EMPTY;
            end else if (req_payload.req_type == OP_POP_BACK) begin
               count_in = count_ff - COUNT_WIDTH'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // word read by pops and peeks
   always_comb begin
      read_word = '0;
      if (!is_empty) begin
         unique case (req_payload.req_type) inside
            OP_POP_FRONT, OP_PEEK_FRONT: begin
               read_word = cell_word[0];
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
               read_word = back_word;
            end
            default: begin
            end
         endcase
      end
   end

   // result assembly
   always_comb begin
      rsp_in.data_out   = PORT_WIDTH'(read_word);
      rsp_in.status     = rsp_status;
      rsp_in.fill_count = FILL_WIDTH'(count_in);
   end

   // chain of cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      deq_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_WIDTH'(g)),
         .ctrl       (ctrl),
         .left_word  ((g == 0) ? ctrl.new_word : cell_word[(g == 0) ? 0 : g - 1]),
         .right_word ((g == DEPTH - 1) ? cell_word[g] :
                      cell_word[(g == DEPTH - 1) ? g : g + 1]),
         .word       (cell_word[g]),
         .back_word  (cell_back[g])
      );
   end

   // count and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("fill count beyond depth");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (!reset && accept) |=> rsp_valid)
      else $error("missing result after a taken transaction");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!reset && !accept) |=> !rsp_valid)
      else $error("result without a transaction");

   a_full_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_FULL) |->
      (rsp_payload.fill_count == FILL_WIDTH'(DEPTH) && rsp_payload.data_out == '0))
      else $error("full error while not full");

   a_empty_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_EMPTY) |->
      (rsp_payload.fill_count == '0 && rsp_payload.data_out == '0))
      else $error("empty error while not empty");

endmodule
